>>> design/crg_pkg.sv
// Shared constants for the crop and resize address generator.
package crg_pkg;

   // Register and result field widths
   localparam int REG_W  = 10;
   localparam int ADDR_W = 21;
   localparam int DEST_W = 15;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // Default geometry
   localparam int SOURCE_SIZE_DEF = 640;
   localparam int OUT_HEIGHT_DEF  = 40;
   localparam int OUT_WIDTH_DEF   = 160;
   localparam int PIXEL_BYTES_DEF = 3;

   // Register reset values
   localparam int BOX_X_RESET = 0;
   localparam int BOX_Y_RESET = 0;
   localparam int BOX_W_RESET = 160;
   localparam int BOX_H_RESET = 40;

   // Register indexes (byte address 4*index)
   localparam logic [1:0] REG_BOX_X = 2'd0;
   localparam logic [1:0] REG_BOX_Y = 2'd1;
   localparam logic [1:0] REG_BOX_W = 2'd2;
   localparam logic [1:0] REG_BOX_H = 2'd3;

endpackage

>>> design/crop_resize_address_generator.sv
// Nearest-neighbour crop and resize read address generator.
//
//   port group  direction  handshake                 payload
//   req_        in         req_valid / req_stall     req_restart
//   rsp_        out        rsp_valid / rsp_stall     rsp_source_address, rsp_dest_index,
//                                                    rsp_out_of_range, rsp_last
//   csr_        in/out     APB-style, pready high    box_x, box_y, box_w, box_h
//
// One item per clock unless req_stall is high: an accepted item steps the walk counters
// and loads the result register in the same edge, so the result appears next cycle.
// The rate is set by the single result register, which takes a new item while
// the previous one is being taken downstream.
// Synchronous active-high reset clears the walk and restores the box registers.
// req_stall is high only while the result register is full and rsp_stall holds it.
module crop_resize_address_generator
   import crg_pkg::*;
#(
   parameter int SOURCE_SIZE = SOURCE_SIZE_DEF,
   parameter int OUT_HEIGHT  = OUT_HEIGHT_DEF,
   parameter int OUT_WIDTH   = OUT_WIDTH_DEF,
   parameter int PIXEL_BYTES = PIXEL_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_restart,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ADDR_W-1:0]     rsp_source_address,
   output logic [DEST_W-1:0]     rsp_dest_index,
   output logic                  rsp_out_of_range,
   output logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int COL_W = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
   localparam int ROW_W = (OUT_HEIGHT > 1) ? $clog2(OUT_HEIGHT) : 1;
   localparam int CH_W  = (PIXEL_BYTES > 1) ? $clog2(PIXEL_BYTES) : 1;
   localparam int OFF_W = REG_W + 1;
   localparam int SUM_W = REG_W + 2;
   localparam int SRC_W = $clog2(SOURCE_SIZE);
   localparam int MUL_W = 32;

   localparam logic [COL_W-1:0] COL_LAST = COL_W'(OUT_WIDTH - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(OUT_HEIGHT - 1);
   localparam logic [CH_W-1:0]  CH_LAST  = CH_W'(PIXEL_BYTES - 1);
   localparam logic [SRC_W-1:0] SRC_MAX  = SRC_W'(SOURCE_SIZE - 1);

   // Reciprocal constants: floor(v*MUL >> SHIFT) == floor(v/divisor) for all v < 2**REG_W
   localparam int    C_SHIFT  = REG_W + COL_W;
   localparam longint C_MUL   = ((64'd1 << C_SHIFT) + OUT_WIDTH - 1) / OUT_WIDTH;
   localparam int    C_PROD_W = REG_W + C_SHIFT + 1;
   localparam int    R_SHIFT  = REG_W + ROW_W;
   localparam longint R_MUL   = ((64'd1 << R_SHIFT) + OUT_HEIGHT - 1) / OUT_HEIGHT;
   localparam int    R_PROD_W = REG_W + R_SHIFT + 1;

   localparam logic [REG_W-1:0] COL_Q_RESET = REG_W'(BOX_W_RESET / OUT_WIDTH);
   localparam logic [COL_W-1:0] COL_R_RESET = COL_W'(BOX_W_RESET % OUT_WIDTH);
   localparam logic [REG_W-1:0] ROW_Q_RESET = REG_W'(BOX_H_RESET / OUT_HEIGHT);
   localparam logic [ROW_W-1:0] ROW_R_RESET = ROW_W'(BOX_H_RESET % OUT_HEIGHT);

   // Configuration registers and their step increments
   logic [REG_W-1:0] box_x_ff, box_y_ff, box_w_ff, box_h_ff;
   logic [REG_W-1:0] col_q_ff, row_q_ff;
   logic [COL_W-1:0] col_r_ff;
   logic [ROW_W-1:0] row_r_ff;

   logic              csr_write;
   logic [1:0]        csr_index;
   logic [REG_W-1:0]  wdata;
   logic [C_PROD_W-1:0] wc_prod;
   logic [REG_W-1:0]  wc_q;
   logic [COL_W-1:0]  wc_r;
   logic [R_PROD_W-1:0] wr_prod;
   logic [REG_W-1:0]  wr_q;
   logic [ROW_W-1:0]  wr_r;

   // Walk state
   logic [COL_W-1:0] out_column_ff, out_column_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic [CH_W-1:0]  channel_ff, channel_in;
   logic [OFF_W-1:0] col_off_ff, col_off_in;
   logic [COL_W-1:0] col_rem_ff, col_rem_in;
   logic [OFF_W-1:0] row_off_ff, row_off_in;
   logic [ROW_W-1:0] row_rem_ff, row_rem_in;

   logic [COL_W-1:0] e_col;
   logic [ROW_W-1:0] e_row;
   logic [CH_W-1:0]  e_ch;
   logic [OFF_W-1:0] e_coff, e_roff;
   logic [COL_W-1:0] e_crem;
   logic [ROW_W-1:0] e_rrem;

   logic [COL_W:0]   col_sum;
   logic             col_carry;
   logic [ROW_W:0]   row_sum;
   logic             row_carry;
   logic             ch_wrap, row_wrap, col_wrap;

   logic [SUM_W-1:0] src_col_sum, src_row_sum;
   logic             col_beyond, row_beyond;
   logic [SRC_W-1:0] src_col, src_row;
   logic [MUL_W-1:0] addr_full, dest_full;
   logic             is_last;

   // Result register
   logic              load;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] address_ff;
   logic [DEST_W-1:0] dest_ff;
   logic              beyond_ff, last_ff;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[3:2];
   assign wdata      = csr_pwdata[REG_W-1:0];

   always_comb begin
      wc_prod = C_PROD_W'(wdata) * C_PROD_W'(C_MUL);
      wc_q    = REG_W'(wc_prod >> C_SHIFT);
      wc_r    = COL_W'(C_PROD_W'(wdata) - C_PROD_W'(wc_q) * C_PROD_W'(OUT_WIDTH));
      wr_prod = R_PROD_W'(wdata) * R_PROD_W'(R_MUL);
      wr_q    = REG_W'(wr_prod >> R_SHIFT);
      wr_r    = ROW_W'(R_PROD_W'(wdata) - R_PROD_W'(wr_q) * R_PROD_W'(OUT_HEIGHT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff <= REG_W'(BOX_X_RESET);
         box_y_ff <= REG_W'(BOX_Y_RESET);
         box_w_ff <= REG_W'(BOX_W_RESET);
         box_h_ff <= REG_W'(BOX_H_RESET);
         col_q_ff <= COL_Q_RESET;
         col_r_ff <= COL_R_RESET;
         row_q_ff <= ROW_Q_RESET;
         row_r_ff <= ROW_R_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_BOX_X: begin
               box_x_ff <= wdata;
            end
            REG_BOX_Y: begin
               box_y_ff <= wdata;
            end
            REG_BOX_W: begin
               box_w_ff <= wdata;
               col_q_ff <= wc_q;
               col_r_ff <= wc_r;
            end
            REG_BOX_H: begin
               box_h_ff <= wdata;
               row_q_ff <= wr_q;
               row_r_ff <= wr_r;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_BOX_X: csr_prdata = CSR_DATA_W'(box_x_ff);
         REG_BOX_Y: csr_prdata = CSR_DATA_W'(box_y_ff);
         REG_BOX_W: csr_prdata = CSR_DATA_W'(box_w_ff);
         REG_BOX_H: csr_prdata = CSR_DATA_W'(box_h_ff);
         default:   csr_prdata = '0;
      endcase
   end

   // ---------------- walk ----------------
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign load      = req_valid & ~req_stall;

   // restart applies before this item is produced
   always_comb begin
      if (req_restart) begin
         e_col  = '0;
         e_row  = '0;
         e_ch   = '0;
         e_coff = '0;
         e_crem = '0;
         e_roff = '0;
         e_rrem = '0;
      end else begin
         e_col  = out_column_ff;
         e_row  = out_row_ff;
         e_ch   = channel_ff;
         e_coff = col_off_ff;
         e_crem = col_rem_ff;
         e_roff = row_off_ff;
         e_rrem = row_rem_ff;
      end
   end

   always_comb begin
      col_sum   = {1'b0, e_crem} + {1'b0, col_r_ff};
      col_carry = col_sum >= (COL_W+1)'(OUT_WIDTH);
      row_sum   = {1'b0, e_rrem} + {1'b0, row_r_ff};
      row_carry = row_sum >= (ROW_W+1)'(OUT_HEIGHT);
      ch_wrap   = e_ch == CH_LAST;
      row_wrap  = e_row == ROW_LAST;
      col_wrap  = e_col == COL_LAST;

      out_column_in = e_col;
      out_row_in    = e_row;
      col_off_in    = e_coff;
      col_rem_in    = e_crem;
      row_off_in    = e_roff;
      row_rem_in    = e_rrem;
      channel_in    = ch_wrap ? '0 : e_ch + 1'b1;

      if (ch_wrap) begin
         if (!row_wrap) begin
            out_row_in = e_row + 1'b1;
            row_off_in = e_roff + OFF_W'(row_q_ff) + OFF_W'(row_carry);
            row_rem_in = row_carry ? ROW_W'(row_sum - (ROW_W+1)'(OUT_HEIGHT))
                                   : ROW_W'(row_sum);
         end else begin
            out_row_in = '0;
            row_off_in = '0;
            row_rem_in = '0;
            if (!col_wrap) begin
               out_column_in = e_col + 1'b1;
               col_off_in    = e_coff + OFF_W'(col_q_ff) + OFF_W'(col_carry);
               col_rem_in    = col_carry ? COL_W'(col_sum - (COL_W+1)'(OUT_WIDTH))
                                         : COL_W'(col_sum);
            end else begin
               out_column_in = '0;
               col_off_in    = '0;
               col_rem_in    = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_column_ff <= '0;
         out_row_ff    <= '0;
         channel_ff    <= '0;
         col_off_ff    <= '0;
         col_rem_ff    <= '0;
         row_off_ff    <= '0;
         row_rem_ff    <= '0;
      end else if (load) begin
         out_column_ff <= out_column_in;
         out_row_ff    <= out_row_in;
         channel_ff    <= channel_in;
         col_off_ff    <= col_off_in;
         col_rem_ff    <= col_rem_in;
         row_off_ff    <= row_off_in;
         row_rem_ff    <= row_rem_in;
      end
   end

   // ---------------- address and index ----------------
   always_comb begin
      src_col_sum = SUM_W'(box_x_ff) + SUM_W'(e_coff);
      src_row_sum = SUM_W'(box_y_ff) + SUM_W'(e_roff);
      col_beyond  = 32'(src_col_sum) >= 32'(SOURCE_SIZE);
      row_beyond  = 32'(src_row_sum) >= 32'(SOURCE_SIZE);
      src_col     = col_beyond ? SRC_MAX : SRC_W'(src_col_sum);
      src_row     = row_beyond ? SRC_MAX : SRC_W'(src_row_sum);
      addr_full   = MUL_W'(src_row) * MUL_W'(SOURCE_SIZE * PIXEL_BYTES)
                  + MUL_W'(src_col) * MUL_W'(PIXEL_BYTES) + MUL_W'(e_ch);
      dest_full   = (MUL_W'(e_col) * MUL_W'(OUT_HEIGHT) + MUL_W'(e_row))
                  * MUL_W'(PIXEL_BYTES) + MUL_W'(e_ch);
      is_last     = col_wrap & row_wrap & ch_wrap;
   end

   // ---------------- result register ----------------
   assign rsp_valid_in = load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         address_ff <= addr_full[ADDR_W-1:0];
         dest_ff    <= dest_full[DEST_W-1:0];
         beyond_ff  <= col_beyond | row_beyond;
         last_ff    <= is_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_source_address = address_ff;
   assign rsp_dest_index     = dest_ff;
   assign rsp_out_of_range   = beyond_ff;
   assign rsp_last           = last_ff;

endmodule
